// File: rtl/stp_pkg.sv
package stp_pkg;

  // field widths
  localparam int TS_W   = 63;
  localparam int SKEW_W = 33;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 64;
  localparam int WIN_W  = 32;

  // defaults
  localparam int                DEPTH_DEF    = 16;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd8333333;

endpackage

// File: rtl/stp_in_if.sv
interface stp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         side;
  logic [stp_pkg::TS_W-1:0]     frame_ts;

  modport source (output valid, side, frame_ts, input ready);
  modport sink   (input valid, side, frame_ts, output ready);
endinterface

// File: rtl/stp_out_if.sv
interface stp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             paired;
  logic signed [stp_pkg::SKEW_W-1:0] skew_ns;
  logic [stp_pkg::CNT_W-1:0]        pair_count;
  logic signed [stp_pkg::SUM_W-1:0] skew_sum;

  modport source (output valid, paired, skew_ns, pair_count, skew_sum, input ready);
  modport sink   (input valid, paired, skew_ns, pair_count, skew_sum, output ready);
endinterface

// File: rtl/stp_list_mem.sv
module stp_list_mem #(
  parameter int AW = 5,
  parameter int DW = 63
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/stereo_timestamp_pairing.sv
// channel  dir  beat contents
// in_ch    in   side, frame_ts
// out_ch   out  paired, skew_ns, pair_count, skew_sum
// cfg_     in   cfg_we / cfg_wdata write match_window, no read-back
//
// one beat at a time: a beat searches the opposite list; a pair then passes the
// check, skew and sum states and two compaction sweeps, an append into a full list
// one shift sweep; the next beat is taken once the result is in the output register.
// the sweeps are paced by the one read port of the list memory, one entry a cycle.
// synchronous active-low reset empties both lists, clears count and sum.
// a finished result waits in the output register while the next beat is taken.
module stereo_timestamp_pairing #(
  parameter int DEPTH = stp_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  stp_in_if.sink                    in_ch,
  stp_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [stp_pkg::WIN_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = IW + 1;
  localparam int TW = stp_pkg::TS_W;
  localparam int SW = stp_pkg::SKEW_W;
  localparam int UW = stp_pkg::SUM_W;
  localparam int NW = stp_pkg::CNT_W;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_CHECK, ST_SKEW, ST_SUM,
    ST_PASS_OTHER, ST_PASS_OWN, ST_SHIFT, ST_APPEND, ST_DONE
  } state_t;

  state_t               state_r;
  logic                 side_r;
  logic [TW-1:0]        ts_r;
  logic [stp_pkg::WIN_W-1:0] window_r;
  logic [1:0][CW-1:0]   fill_r;
  logic [NW-1:0]        pairs_r;
  logic signed [UW-1:0] total_r;
  logic                 paired_r;
  logic signed [SW-1:0] skew_r;
  logic [TW-1:0]        cutoff_r;
  logic                 skip_en_r;
  logic [IW-1:0]        skip_idx_r;
  logic [CW-1:0]        iss_r;
  logic [CW-1:0]        k_r;
  logic                 p1_vld_r;
  logic [IW-1:0]        p1_idx_r;
  logic                 s_vld_r;
  logic [TW-1:0]        s_d_r;
  logic [TW-1:0]        s_t_r;
  logic [IW-1:0]        s_idx_r;
  logic                 best_vld_r;
  logic [TW-1:0]        bestd_r;
  logic [TW-1:0]        ots_r;
  logic [IW-1:0]        best_idx_r;
  logic                 out_vld_r;
  logic                 out_paired_r;
  logic signed [SW-1:0] out_skew_r;
  logic [NW-1:0]        out_count_r;
  logic signed [UW-1:0] out_sum_r;

  logic          cur_side;
  logic [CW-1:0] cur_fill;
  logic [CW-1:0] own_fill;
  logic          scanning;
  logic          pass_st;
  logic          issuing;
  logic          drained;
  logic          keep;
  logic          better;
  logic          window_ok;
  logic [TW-1:0] gap;
  logic [UW:0]   sum_ext;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [TW-1:0] rd_data;

  // list storage: left list in the low half, right list in the high half
  stp_list_mem #(
    .AW (AW),
    .DW (TW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // which list the sweep walks
  always_comb begin
    cur_side = (state_r == ST_SEARCH || state_r == ST_PASS_OTHER) ? ~side_r : side_r;
    cur_fill = fill_r[cur_side];
    own_fill = fill_r[side_r];
    scanning = (state_r == ST_SEARCH) || (state_r == ST_PASS_OTHER) ||
               (state_r == ST_PASS_OWN) || (state_r == ST_SHIFT);
    pass_st  = scanning && (state_r != ST_SEARCH);
    issuing  = scanning && (iss_r < cur_fill);
    drained  = !issuing && !p1_vld_r;
    rd_addr  = {cur_side, iss_r[IW-1:0]};
  end

  // shared distance unit and compaction keep test
  always_comb begin
    gap       = (rd_data >= ts_r) ? rd_data - ts_r : ts_r - rd_data;
    better    = s_vld_r && (!best_vld_r || s_d_r < bestd_r);
    keep      = pass_st && p1_vld_r && !(skip_en_r && p1_idx_r == skip_idx_r) &&
                (rd_data >= cutoff_r);
    window_ok = bestd_r <= {{(TW - stp_pkg::WIN_W){1'b0}}, window_r};
    sum_ext   = {total_r[UW-1], total_r} + {{(UW + 1 - SW){skew_r[SW-1]}}, skew_r};
  end

  // write port: compaction writes or the final append
  always_comb begin
    if (state_r == ST_APPEND) begin
      wr_en   = 1'b1;
      wr_addr = {side_r, own_fill[IW-1:0]};
      wr_data = ts_r;
    end else begin
      wr_en   = keep;
      wr_addr = {cur_side, k_r[IW-1:0]};
      wr_data = rd_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      window_r   <= stp_pkg::WINDOW_RESET;
      fill_r     <= '0;
      pairs_r    <= '0;
      total_r    <= '0;
      out_vld_r  <= 1'b0;
      p1_vld_r   <= 1'b0;
      s_vld_r    <= 1'b0;
      best_vld_r <= 1'b0;
      skip_en_r  <= 1'b0;
      iss_r      <= '0;
      k_r        <= '0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      // the done state reloads the output register itself
      if (out_vld_r && out_ch.ready && state_r != ST_DONE) begin
        out_vld_r <= 1'b0;
      end

      // read pipeline
      if (issuing) begin
        iss_r <= iss_r + 1'b1;
      end
      p1_vld_r <= issuing;
      p1_idx_r <= iss_r[IW-1:0];
      s_vld_r  <= (state_r == ST_SEARCH) && p1_vld_r;
      s_d_r    <= gap;
      s_t_r    <= rd_data;
      s_idx_r  <= p1_idx_r;
      if (keep) begin
        k_r <= k_r + 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            side_r     <= in_ch.side;
            ts_r       <= in_ch.frame_ts;
            paired_r   <= 1'b0;
            skew_r     <= '0;
            iss_r      <= '0;
            k_r        <= '0;
            best_vld_r <= 1'b0;
            if (fill_r[~in_ch.side] != '0) begin
              state_r <= ST_SEARCH;
            end else if (fill_r[in_ch.side] == FULL) begin
              skip_en_r  <= 1'b1;
              skip_idx_r <= '0;
              cutoff_r   <= '0;
              state_r    <= ST_SHIFT;
            end else begin
              state_r <= ST_APPEND;
            end
          end
        end
        ST_SEARCH: begin
          // strict compare keeps the oldest entry on a tie
          if (better) begin
            best_vld_r <= 1'b1;
            bestd_r    <= s_d_r;
            ots_r      <= s_t_r;
            best_idx_r <= s_idx_r;
          end
          if (drained && !s_vld_r) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          iss_r <= '0;
          k_r   <= '0;
          if (window_ok) begin
            state_r <= ST_SKEW;
          end else if (own_fill == FULL) begin
            skip_en_r  <= 1'b1;
            skip_idx_r <= '0;
            cutoff_r   <= '0;
            state_r    <= ST_SHIFT;
          end else begin
            state_r <= ST_APPEND;
          end
        end
        ST_SKEW: begin
          // magnitude fits in the low bits, so a narrow subtract is exact
          skew_r   <= side_r ? $signed(ts_r[SW-1:0] - ots_r[SW-1:0])
                             : $signed(ots_r[SW-1:0] - ts_r[SW-1:0]);
          cutoff_r <= (ts_r < ots_r) ? ts_r : ots_r;
          paired_r <= 1'b1;
          state_r  <= ST_SUM;
        end
        ST_SUM: begin
          if (pairs_r != '1) begin
            pairs_r <= pairs_r + 1'b1;
          end
          // saturate on signed overflow of the running sum
          if (sum_ext[UW] != sum_ext[UW-1]) begin
            total_r <= sum_ext[UW] ? {1'b1, {(UW - 1){1'b0}}} : {1'b0, {(UW - 1){1'b1}}};
          end else begin
            total_r <= $signed(sum_ext[UW-1:0]);
          end
          skip_en_r  <= 1'b1;
          skip_idx_r <= best_idx_r;
          iss_r      <= '0;
          k_r        <= '0;
          state_r    <= ST_PASS_OTHER;
        end
        ST_PASS_OTHER: begin
          if (drained) begin
            fill_r[~side_r] <= k_r;
            skip_en_r       <= 1'b0;
            iss_r           <= '0;
            k_r             <= '0;
            state_r         <= ST_PASS_OWN;
          end
        end
        ST_PASS_OWN: begin
          if (drained) begin
            fill_r[side_r] <= k_r;
            state_r        <= ST_DONE;
          end
        end
        ST_SHIFT: begin
          if (drained) begin
            fill_r[side_r] <= k_r;
            skip_en_r      <= 1'b0;
            state_r        <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          fill_r[side_r] <= own_fill + 1'b1;
          state_r        <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_vld_r || out_ch.ready) begin
            out_vld_r    <= 1'b1;
            out_paired_r <= paired_r;
            out_skew_r   <= skew_r;
            out_count_r  <= pairs_r;
            out_sum_r    <= total_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // ports
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_vld_r;
  assign out_ch.paired     = out_paired_r;
  assign out_ch.skew_ns    = out_skew_r;
  assign out_ch.pair_count = out_count_r;
  assign out_ch.skew_sum   = out_sum_r;

endmodule

// File: sim/stereo_timestamp_pairing_tb.sv
module stereo_timestamp_pairing_tb;

  localparam int TS_W   = stp_pkg::TS_W;
  localparam int SKEW_W = stp_pkg::SKEW_W;
  localparam int CNT_W  = stp_pkg::CNT_W;
  localparam int SUM_W  = stp_pkg::SUM_W;
  localparam int WIN_W  = stp_pkg::WIN_W;
  localparam int DEPTH_DEF = stp_pkg::DEPTH_DEF;
  localparam logic [WIN_W-1:0] WINDOW_RESET = stp_pkg::WINDOW_RESET;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam int FRAME_PERIOD = 16_666_667;
  // worst block latency per beat, from the list sweeps
  localparam int BEAT_CYCLES = 3 * DEPTH_DEF + 12;
  // longest legal quiet stretch is the receiver hold-off, well under this
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic                     paired;
    logic signed [SKEW_W-1:0] skew;
    logic [CNT_W-1:0]         count;
    logic signed [SUM_W-1:0]  sum;
  } pair_report_t;

  // pending lists, pair statistics and the expected reports
  class pair_predictor;
    logic [TS_W-1:0]         left_q[$];
    logic [TS_W-1:0]         right_q[$];
    logic [WIN_W-1:0]        window;
    logic [CNT_W-1:0]        pairs_found;
    logic signed [SUM_W-1:0] skew_total;
    pair_report_t            expected_reports[$];
    int                      errors;

    function new();
      window      = WINDOW_RESET;
      pairs_found = '0;
      skew_total  = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // accepted frame: search, pair or append, queue the report
    function void note_frame(logic side, logic [TS_W-1:0] ts);
      logic [TS_W-1:0]         opp[$];
      logic [TS_W-1:0]         own[$];
      logic [TS_W-1:0]         d, bestd, ots, cutoff;
      logic signed [SUM_W-1:0] diff;
      logic [SUM_W:0]          acc;
      pair_report_t            rep;
      int                      best;
      rep.paired = 1'b0;
      rep.skew   = '0;
      best  = -1;
      bestd = '0;
      opp = side ? left_q : right_q;
      // nearest opposite entry, oldest wins a tie
      foreach (opp[i]) begin
        d = (opp[i] > ts) ? opp[i] - ts : ts - opp[i];
        if (best < 0 || d < bestd) begin
          best  = i;
          bestd = d;
        end
      end
      if (best >= 0 && bestd <= {{(TS_W-WIN_W){1'b0}}, window}) begin
        ots = opp[best];
        opp.delete(best);
        if (side) left_q = opp;
        else right_q = opp;
        cutoff = (ts < ots) ? ts : ots;
        diff = side ? ({1'b0, ts} - {1'b0, ots}) : ({1'b0, ots} - {1'b0, ts});
        rep.paired = 1'b1;
        rep.skew   = diff[SKEW_W-1:0];
        if (pairs_found != '1) pairs_found++;
        // saturating sum: overflow when the two top bits disagree
        acc = {skew_total[SUM_W-1], skew_total} + {diff[SUM_W-1], diff};
        if (acc[SUM_W] != acc[SUM_W-1])
          skew_total = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
          skew_total = acc[SUM_W-1:0];
        left_q  = left_q.find(e) with (e >= cutoff);
        right_q = right_q.find(e) with (e >= cutoff);
      end else begin
        own = side ? right_q : left_q;
        if (own.size() >= DEPTH_DEF) void'(own.pop_front());
        own = {own, ts};
        if (side) right_q = own;
        else left_q = own;
      end
      rep.count = pairs_found;
      rep.sum   = skew_total;
      expected_reports = {expected_reports, rep};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // result beat against the oldest expectation
    function void check_report(logic paired, logic signed [SKEW_W-1:0] skew,
                               logic [CNT_W-1:0] count, logic signed [SUM_W-1:0] sum);
      pair_report_t rep;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, actual %0h/%0h/%0h/%0h",
                 $time, paired, skew, count, sum);
        return;
      end
      rep = expected_reports.pop_front();
      compare_field("paired", rep.paired, paired);
      compare_field("skew_ns", rep.skew, skew);
      compare_field("pair_count", rep.count, count);
      compare_field("skew_sum", rep.sum, sum);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [WIN_W-1:0] cfg_wdata;
  logic sink_held = 1'b0;
  int src_idle_pct = 31;
  int snk_idle_pct = 65;
  int frames_sent = 0;
  int reports_seen = 0;
  int pairs_seen = 0;
  int windows_used = 0;
  int stall_cycles = 0;
  pair_predictor predictor = new();

  stp_in_if  in_ch();
  stp_out_if out_ch();

  stereo_timestamp_pairing #(.DEPTH(DEPTH_DEF)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: check each beat, then pick next ready
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (out_ch.paired) pairs_seen++;
        predictor.check_report(out_ch.paired, out_ch.skew_ns, out_ch.pair_count,
                               out_ch.skew_sum);
      end
      out_ch.ready <= !sink_held && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d reports still expected", $time,
               STALL_LIMIT, predictor.pending());
      $display("stereo_timestamp_pairing_tb: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one frame beat; called just after a rising edge
  task automatic send_frame(input logic side, input logic [TS_W-1:0] ts);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.side     <= side;
    in_ch.frame_ts <= ts;
    do @(posedge clk); while (!in_ch.ready);
    predictor.note_frame(side, ts);
    frames_sent++;
  endtask

  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    predictor.window = w;
    windows_used++;
  endtask

  task automatic hold_receiver(input int cycles);
    sink_held <= 1'b1;
    repeat (cycles) @(posedge clk);
    sink_held <= 1'b0;
  endtask

  // camera streams: mostly near pairs, some lone frames, some noise
  task automatic run_stream(input int frames);
    logic [63:0] now, spread, tl, tr;
    int sent, pick;
    sent = 0;
    now = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 1000)) : (rand64() >> 1);
    while (sent < frames) begin
      if (now > 64'(TS_MAX) - (64'd1 << 36)) now = 64'($urandom_range(0, 1000));
      spread = 64'(predictor.window) + 64'(predictor.window >> 1) + 64'd2;
      tl = now + rand64() % (spread + 64'd1);
      tr = ($urandom_range(0, 6) == 0) ? tl : now + rand64() % (spread + 64'd1);
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_frame(1'($urandom_range(0, 1)), TS_W'(rand64()));
        sent++;
      end else if (pick < 14) begin
        if ($urandom_range(0, 1) != 0) send_frame(SIDE_LEFT, TS_W'(tl));
        else send_frame(SIDE_RIGHT, TS_W'(tr));
        sent++;
      end else begin
        if ($urandom_range(0, 1) != 0) begin
          send_frame(SIDE_LEFT, TS_W'(tl));
          send_frame(SIDE_RIGHT, TS_W'(tr));
        end else begin
          send_frame(SIDE_RIGHT, TS_W'(tr));
          send_frame(SIDE_LEFT, TS_W'(tl));
        end
        sent += 2;
      end
      now += 64'(FRAME_PERIOD) + 64'($urandom_range(0, 20000));
    end
  endtask

  // directed frames at the reset window
  task automatic run_directed();
    // right list empty, then a distance equal to the window
    send_frame(SIDE_LEFT, '0);
    send_frame(SIDE_RIGHT, 63'd8_333_333);
    // one past the window, then a negative skew that purges the right list
    send_frame(SIDE_RIGHT, 63'd50_000_000);
    send_frame(SIDE_LEFT, 63'd58_333_334);
    send_frame(SIDE_RIGHT, 63'd58_333_329);
    // equal distances: the older entry wins
    send_frame(SIDE_LEFT, 63'd100_000_000);
    send_frame(SIDE_LEFT, 63'd100_000_020);
    send_frame(SIDE_RIGHT, 63'd100_000_010);
    // overfill the left list, topmost timestamp last
    for (int k = 1; k <= 15; k++)
      send_frame(SIDE_LEFT, TS_W'(64'(k) * 64'd1_000_000_000));
    send_frame(SIDE_LEFT, TS_MAX);
    send_frame(SIDE_RIGHT, TS_MAX - 63'd3);
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.side     <= SIDE_LEFT;
    in_ch.frame_ts <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles less than the receiver
    run_directed();
    fork
      hold_receiver(HOLD_CYCLES);
      run_stream(300);
    join
    drain_reports();
    write_window('0);
    run_stream(150);
    drain_reports();

    // receiver idles less than the sender
    src_idle_pct = 65;
    snk_idle_pct = 31;
    write_window('1);
    run_stream(250);
    drain_reports();
    write_window($urandom());
    run_stream(250);
    drain_reports();

    // no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_window(WIN_W'($urandom_range(0, 2000)));
    run_stream(150);
    drain_reports();
    write_window(WINDOW_RESET);
    run_stream(150);
    drain_reports();

    repeat (BEAT_CYCLES) @(posedge clk);
    $display("run covered %0d frames, %0d reports, %0d pairs, %0d window settings",
             frames_sent, reports_seen, pairs_seen, windows_used);
    $display("with receiver hold-off, full lists, ties, window edges and timestamp extremes");
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("stereo_timestamp_pairing_tb: clean");
    end else begin
      $display("%0d mismatches, %0d reports missing", predictor.errors, predictor.pending());
      $display("stereo_timestamp_pairing_tb: errors");
    end
    $finish;
  end

endmodule

// File: stereo_timestamp_pairing.f
rtl/stp_pkg.sv
rtl/stp_in_if.sv
rtl/stp_out_if.sv
rtl/stp_list_mem.sv
rtl/stereo_timestamp_pairing.sv
sim/stereo_timestamp_pairing_tb.sv
